// File: design/tvls_pkg.sv
// Package for the tag/value list splitter.
// Holds payload structs, character codes, status codes and the phase enum.
// No dependencies.
package tvls_pkg;

  localparam int MAX_LEN = 4096;
  localparam int POS_W   = $clog2(MAX_LEN + 1);
  localparam int NS_W    = 12;
  localparam int LEN_W   = 13;

  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_EQ    = 2'd1;
  localparam logic [1:0] ST_NO_NAME  = 2'd2;
  localparam logic [1:0] ST_TOO_LONG = 2'd3;

  typedef enum logic [1:0] {
    PH_NAME    = 2'd0,
    PH_VALUE   = 2'd1,
    PH_DISCARD = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       byte_present;
    logic       last;
  } tvls_in_t;

  typedef struct packed {
    logic             tag_found;
    logic [NS_W-1:0]  name_start;
    logic [LEN_W-1:0] name_length;
    logic [LEN_W-1:0] value_start;
    logic [LEN_W-1:0] value_length;
    logic [1:0]       status;
    logic             end_of_list;
  } tvls_out_t;

  function automatic logic is_space(input logic [7:0] c);
    return c inside {CH_SPACE, CH_TAB, CH_CR, CH_LF};
  endfunction

endpackage

// File: design/tag_value_list_splitter.sv
// Top level of the tag/value list splitter.
// Instantiates tvls_parse and tvls_out_buf; depends on tvls_pkg.
//
// Takes a tag=value list one byte per transfer and, for every non-blank
// ';'-separated segment, returns the offsets and lengths of the trimmed name
// and value. A byte goes into an input register, is parsed and its result
// (if any) lands in the result register; the block takes one byte per clock
// and out_valid rises once the byte has passed both registers. It stalls
// only when the result register is full and out_ready is low. The byte
// marked last yields exactly one result with end_of_list set, unless an
// error came earlier in the message; an error yields one result with
// end_of_list set and the rest of the message is dropped through its last byte.
module tag_value_list_splitter (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tvls_pkg::tvls_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tvls_pkg::tvls_out_t out_data
);

  logic                s1_valid_r;
  tvls_pkg::tvls_in_t  s1_item_r;
  logic                can_take;
  logic                fire;
  logic                res_valid;
  tvls_pkg::tvls_out_t res;

  assign fire     = s1_valid_r && can_take;
  assign in_ready = !s1_valid_r || can_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item_r <= in_data;
    end
  end

  tvls_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .item      (s1_item_r),
    .res_valid (res_valid),
    .res       (res)
  );

  tvls_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .can_take  (can_take),
    .load      (fire && res_valid),
    .load_data (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: design/tvls_parse.sv
// Parser state and per-byte logic of the tag/value list splitter.
// Depends on tvls_pkg.
module tvls_parse (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  tvls_pkg::tvls_in_t  item,
  output logic                res_valid,
  output tvls_pkg::tvls_out_t res
);

  logic [tvls_pkg::POS_W-1:0] position_r, position_nxt;
  tvls_pkg::phase_t           phase_r, phase_nxt;
  logic [tvls_pkg::NS_W-1:0]  name_first_r, name_first_nxt;
  logic [tvls_pkg::POS_W-1:0] name_end_r, name_end_nxt;
  logic                       name_seen_r, name_seen_nxt;
  logic [tvls_pkg::POS_W-1:0] value_first_r, value_first_nxt;
  logic [tvls_pkg::POS_W-1:0] value_end_r, value_end_nxt;
  logic                       value_seen_r, value_seen_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r    <= '0;
      phase_r       <= tvls_pkg::PH_NAME;
      name_first_r  <= '0;
      name_end_r    <= '0;
      name_seen_r   <= 1'b0;
      value_first_r <= '0;
      value_end_r   <= '0;
      value_seen_r  <= 1'b0;
    end else if (fire) begin
      position_r    <= position_nxt;
      phase_r       <= phase_nxt;
      name_first_r  <= name_first_nxt;
      name_end_r    <= name_end_nxt;
      name_seen_r   <= name_seen_nxt;
      value_first_r <= value_first_nxt;
      value_end_r   <= value_end_nxt;
      value_seen_r  <= value_seen_nxt;
    end
  end

  always_comb begin
    logic tag_out;
    logic err;
    logic clear_seg;
    logic [1:0] err_code;
    logic [tvls_pkg::POS_W-1:0] p;

    tag_out   = 1'b0;
    err       = 1'b0;
    clear_seg = 1'b0;
    err_code  = tvls_pkg::ST_OK;
    p         = position_r;

    position_nxt    = position_r;
    phase_nxt       = phase_r;
    name_first_nxt  = name_first_r;
    name_end_nxt    = name_end_r;
    name_seen_nxt   = name_seen_r;
    value_first_nxt = value_first_r;
    value_end_nxt   = value_end_r;
    value_seen_nxt  = value_seen_r;
    res_valid       = 1'b0;
    res             = '0;

    // tag spans from the segment as it stood before this byte
    res.tag_found    = 1'b0;
    res.name_start   = name_first_r;
    res.name_length  = tvls_pkg::LEN_W'(name_end_r - tvls_pkg::POS_W'(name_first_r));
    res.value_start  = value_seen_r ? tvls_pkg::LEN_W'(value_first_r) : '0;
    res.value_length = value_seen_r ?
                       tvls_pkg::LEN_W'(value_end_r - value_first_r) : '0;

    if (phase_r inside {tvls_pkg::PH_NAME, tvls_pkg::PH_VALUE}) begin
      if (item.byte_present) begin
        if (p >= tvls_pkg::POS_W'(tvls_pkg::MAX_LEN)) begin
          err      = 1'b1;
          err_code = tvls_pkg::ST_TOO_LONG;
        end else begin
          position_nxt = p + 1'b1;
          if (item.byte_value == tvls_pkg::CH_SEMI) begin
            if (phase_r == tvls_pkg::PH_VALUE) begin
              tag_out   = 1'b1;
              clear_seg = 1'b1;
            end else if (name_seen_r) begin
              err      = 1'b1;
              err_code = tvls_pkg::ST_NO_EQ;
            end else begin
              clear_seg = 1'b1;
            end
          end else if (phase_r == tvls_pkg::PH_NAME &&
                       item.byte_value == tvls_pkg::CH_EQ) begin
            if (!name_seen_r) begin
              err      = 1'b1;
              err_code = tvls_pkg::ST_NO_NAME;
            end else begin
              phase_nxt = tvls_pkg::PH_VALUE;
            end
          end else if (!tvls_pkg::is_space(item.byte_value)) begin
            if (phase_r == tvls_pkg::PH_NAME) begin
              if (!name_seen_r) begin
                name_first_nxt = p[tvls_pkg::NS_W-1:0];
                name_seen_nxt  = 1'b1;
              end
              name_end_nxt = p + 1'b1;
            end else begin
              if (!value_seen_r) begin
                value_first_nxt = p;
                value_seen_nxt  = 1'b1;
              end
              value_end_nxt = p + 1'b1;
            end
          end
        end
      end

      if (clear_seg) begin
        phase_nxt       = tvls_pkg::PH_NAME;
        name_first_nxt  = '0;
        name_end_nxt    = '0;
        name_seen_nxt   = 1'b0;
        value_first_nxt = '0;
        value_end_nxt   = '0;
        value_seen_nxt  = 1'b0;
      end

      if (err) begin
        res_valid       = 1'b1;
        res             = '0;
        res.status      = err_code;
        res.end_of_list = 1'b1;
        phase_nxt       = tvls_pkg::PH_DISCARD;
      end else if (tag_out) begin
        res_valid       = 1'b1;
        res.tag_found   = 1'b1;
        res.end_of_list = item.last;
      end else if (item.last) begin
        // end of message: close whatever segment is open
        res_valid = 1'b1;
        res       = '0;
        if (phase_nxt == tvls_pkg::PH_VALUE) begin
          res.tag_found    = 1'b1;
          res.name_start   = name_first_nxt;
          res.name_length  = tvls_pkg::LEN_W'(name_end_nxt -
                                              tvls_pkg::POS_W'(name_first_nxt));
          res.value_start  = value_seen_nxt ? tvls_pkg::LEN_W'(value_first_nxt) : '0;
          res.value_length = value_seen_nxt ?
                             tvls_pkg::LEN_W'(value_end_nxt - value_first_nxt) : '0;
        end else if (name_seen_nxt) begin
          res.status = tvls_pkg::ST_NO_EQ;
        end
        res.end_of_list = 1'b1;
      end
    end

    if (item.last) begin
      position_nxt    = '0;
      phase_nxt       = tvls_pkg::PH_NAME;
      name_first_nxt  = '0;
      name_end_nxt    = '0;
      name_seen_nxt   = 1'b0;
      value_first_nxt = '0;
      value_end_nxt   = '0;
      value_seen_nxt  = 1'b0;
    end
  end

endmodule

// File: design/tvls_out_buf.sv
// Result register of the tag/value list splitter.
// Holds one result until the downstream transfer; depends on tvls_pkg.
module tvls_out_buf (
  input  logic                clk,
  input  logic                rst_n,
  output logic                can_take,
  input  logic                load,
  input  tvls_pkg::tvls_out_t load_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tvls_pkg::tvls_out_t out_data
);

  logic                valid_r;
  tvls_pkg::tvls_out_t data_r;

  // free now, or emptied by the transfer at this edge
  assign can_take  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (can_take) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (can_take && load) begin
      data_r <= load_data;
    end
  end

endmodule

// File: verif/tb_tag_value_list_splitter.sv
`timescale 1ns / 100ps
// Self-checking testbench for tag_value_list_splitter: queue-fed driver, monitor, span predictor.
// Depends on tvls_pkg and the design sources; needs nothing else.
module tb_tag_value_list_splitter;

  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 500;
  localparam int DRAIN_CYCLES = 20;

  localparam int SEG_GOOD    = 0;
  localparam int SEG_NO_EQ   = 1;
  localparam int SEG_NO_NAME = 2;
  localparam int SEG_BLANK   = 3;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  tvls_pkg::tvls_in_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  tvls_pkg::tvls_out_t out_data;

  tag_value_list_splitter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  tvls_pkg::tvls_in_t  byte_queue[$];
  tvls_pkg::tvls_out_t span_queue[$];
  logic [7:0]          msg_bytes[$];

  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   useful_items = 0;
  int   mismatch_count = 0;
  int   cycle_count = 0;
  int   hold_left = 0;
  logic hold_request = 1'b0;
  logic in_taken = 1'b0;

  // predictor state
  logic [tvls_pkg::POS_W-1:0] list_pos;
  tvls_pkg::phase_t           seg_phase;
  logic [tvls_pkg::NS_W-1:0]  name_first;
  logic [tvls_pkg::LEN_W-1:0] name_end;
  logic [tvls_pkg::LEN_W-1:0] value_first;
  logic [tvls_pkg::LEN_W-1:0] value_end;
  logic                       name_seen;
  logic                       value_seen;

  function automatic logic blank_char(input logic [7:0] b);
    case (b)
      tvls_pkg::CH_SPACE, tvls_pkg::CH_TAB, tvls_pkg::CH_CR, tvls_pkg::CH_LF: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  task automatic clear_segment();
    seg_phase   = tvls_pkg::PH_NAME;
    name_first  = '0;
    name_end    = '0;
    name_seen   = 1'b0;
    value_first = '0;
    value_end   = '0;
    value_seen  = 1'b0;
  endtask

  task automatic clear_list();
    list_pos = '0;
    clear_segment();
  endtask

  function automatic tvls_pkg::tvls_out_t tag_span();
    tvls_pkg::tvls_out_t r;
    r = '0;
    r.tag_found   = 1'b1;
    r.name_start  = name_first;
    r.name_length = name_end - {1'b0, name_first};
    if (value_seen) begin
      r.value_start  = value_first;
      r.value_length = value_end - value_first;
    end
    return r;
  endfunction

  task automatic raise_error(input logic [1:0] code, input logic lst);
    tvls_pkg::tvls_out_t r;
    r = '0;
    r.status      = code;
    r.end_of_list = 1'b1;
    span_queue.push_back(r);
    if (lst) begin
      clear_list();
    end else begin
      seg_phase = tvls_pkg::PH_DISCARD;
    end
  endtask

  task automatic predict_spans(input tvls_pkg::tvls_in_t it);
    tvls_pkg::tvls_out_t        span;
    logic [tvls_pkg::POS_W-1:0] p;
    logic                       closed;
    span = '0;
    closed = 1'b0;
    // anything outside name/value is discard: drop until the last byte
    if (seg_phase != tvls_pkg::PH_NAME && seg_phase != tvls_pkg::PH_VALUE) begin
      if (it.last) clear_list();
      return;
    end
    if (it.byte_present || it.last) useful_items++;
    if (it.byte_present) begin
      p = list_pos;
      if (p >= tvls_pkg::MAX_LEN) begin
        raise_error(tvls_pkg::ST_TOO_LONG, it.last);
        return;
      end
      list_pos = p + 1'b1;
      if (it.byte_value == tvls_pkg::CH_SEMI) begin
        if (seg_phase == tvls_pkg::PH_VALUE) begin
          span = tag_span();
          closed = 1'b1;
          clear_segment();
        end else if (name_seen) begin
          raise_error(tvls_pkg::ST_NO_EQ, it.last);
          return;
        end else begin
          clear_segment();
        end
      end else if (seg_phase == tvls_pkg::PH_NAME && it.byte_value == tvls_pkg::CH_EQ) begin
        if (!name_seen) begin
          raise_error(tvls_pkg::ST_NO_NAME, it.last);
          return;
        end
        seg_phase = tvls_pkg::PH_VALUE;
      end else if (!blank_char(it.byte_value)) begin
        if (seg_phase == tvls_pkg::PH_NAME) begin
          if (!name_seen) begin
            name_first = p[tvls_pkg::NS_W-1:0];
            name_seen  = 1'b1;
          end
          name_end = p + 1'b1;
        end else begin
          if (!value_seen) begin
            value_first = p;
            value_seen  = 1'b1;
          end
          value_end = p + 1'b1;
        end
      end
    end
    if (!it.last) begin
      if (closed) span_queue.push_back(span);
      return;
    end
    // the last transfer always closes the message with exactly one result
    if (!closed) begin
      if (seg_phase == tvls_pkg::PH_VALUE) begin
        span = tag_span();
      end else if (name_seen) begin
        span.status = tvls_pkg::ST_NO_EQ;
      end
    end
    span.end_of_list = 1'b1;
    span_queue.push_back(span);
    clear_list();
  endtask

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  task automatic check_span(input tvls_pkg::tvls_out_t got);
    tvls_pkg::tvls_out_t want;
    if (span_queue.size() == 0) begin
      report_mismatch($sformatf("result %h with nothing expected", got));
      return;
    end
    want = span_queue.pop_front();
    if (got.tag_found !== want.tag_found)
      report_mismatch($sformatf("tag_found %0d, want %0d", got.tag_found, want.tag_found));
    if (got.name_start !== want.name_start)
      report_mismatch($sformatf("name_start %0d, want %0d", got.name_start, want.name_start));
    if (got.name_length !== want.name_length)
      report_mismatch($sformatf("name_length %0d, want %0d", got.name_length,
                                want.name_length));
    if (got.value_start !== want.value_start)
      report_mismatch($sformatf("value_start %0d, want %0d", got.value_start,
                                want.value_start));
    if (got.value_length !== want.value_length)
      report_mismatch($sformatf("value_length %0d, want %0d", got.value_length,
                                want.value_length));
    if (got.status !== want.status)
      report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
    if (got.end_of_list !== want.end_of_list)
      report_mismatch($sformatf("end_of_list %0d, want %0d", got.end_of_list,
                                want.end_of_list));
  endtask

  // ---------------- stimulus helpers ----------------

  task automatic push_item(input logic [7:0] b, input logic present, input logic lst);
    tvls_pkg::tvls_in_t it;
    it.byte_value   = b;
    it.byte_present = present;
    it.last         = lst;
    byte_queue.push_back(it);
  endtask

  function automatic logic [7:0] blank_byte();
    case ($urandom_range(3))
      0: return tvls_pkg::CH_SPACE;
      1: return tvls_pkg::CH_TAB;
      2: return tvls_pkg::CH_CR;
      default: return tvls_pkg::CH_LF;
    endcase
  endfunction

  function automatic logic [7:0] word_byte(input logic allow_eq);
    logic [7:0] b;
    do begin
      if ($urandom_range(3) == 0) b = 8'($urandom_range(255));
      else b = 8'($urandom_range(8'h61, 8'h7A));
    end while (b == tvls_pkg::CH_SEMI || (!allow_eq && b == tvls_pkg::CH_EQ) ||
               blank_char(b));
    return b;
  endfunction

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(5))
      0: return tvls_pkg::CH_SEMI;
      1: return tvls_pkg::CH_EQ;
      2: return blank_byte();
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic add_blanks(input int max_n);
    int n;
    n = $urandom_range(max_n);
    repeat (n) msg_bytes.push_back(blank_byte());
  endtask

  task automatic add_segment(input int kind);
    int n;
    add_blanks(2);
    if (kind == SEG_BLANK) return;
    if (kind != SEG_NO_NAME) begin
      n = $urandom_range(1, 5);
      repeat (n) msg_bytes.push_back(($urandom_range(9) == 0) ? blank_byte() : word_byte(1'b0));
    end
    add_blanks(2);
    if (kind == SEG_NO_EQ) return;
    msg_bytes.push_back(tvls_pkg::CH_EQ);
    add_blanks(2);
    n = $urandom_range(0, 6);
    repeat (n) msg_bytes.push_back(($urandom_range(6) == 0) ? blank_byte() : word_byte(1'b1));
    add_blanks(2);
  endtask

  // message end is either on the final byte or on a bare marker
  task automatic send_message();
    logic bare_end;
    bare_end = (msg_bytes.size() == 0) || ($urandom_range(3) == 0);
    foreach (msg_bytes[i]) begin
      if ($urandom_range(19) == 0) push_item(8'($urandom), 1'b0, 1'b0);
      push_item(msg_bytes[i], 1'b1, !bare_end && (i == msg_bytes.size() - 1));
    end
    if (bare_end) push_item(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic queue_random_message();
    int pick;
    int nseg;
    int bad_seg;
    int n;
    msg_bytes.delete();
    pick = $urandom_range(99);
    if (pick < 15) begin
      n = $urandom_range(1, 20);
      repeat (n) msg_bytes.push_back(noise_byte());
    end else begin
      nseg = $urandom_range(0, 5);
      bad_seg = (pick < 35 && nseg > 0) ? $urandom_range(nseg - 1) : -1;
      for (int s = 0; s < nseg; s++) begin
        if (s > 0) msg_bytes.push_back(tvls_pkg::CH_SEMI);
        if (s == bad_seg) add_segment($urandom_range(1) ? SEG_NO_EQ : SEG_NO_NAME);
        else add_segment(($urandom_range(9) == 0) ? SEG_BLANK : SEG_GOOD);
      end
      if ($urandom_range(2) == 0) msg_bytes.push_back(tvls_pkg::CH_SEMI);
    end
    send_message();
  endtask

  // ---------------- driver, receiver, monitor ----------------

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (byte_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data  <= byte_queue.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && in_ready;
    if (rst_n && out_valid && out_ready) check_span(out_data);
    if (rst_n && in_valid && in_ready) predict_spans(in_data);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------- test sequence ----------------

  initial begin
    int target;
    clear_list();
    send_idle_pct = 26;
    recv_idle_pct = 87;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // tag closed by ';' on the last byte
    push_item("a", 1'b1, 1'b0);
    push_item(tvls_pkg::CH_EQ, 1'b1, 1'b0);
    push_item("b", 1'b1, 1'b0);
    push_item(tvls_pkg::CH_SEMI, 1'b1, 1'b1);
    // empty name, remainder dropped up to a bare end marker
    push_item(tvls_pkg::CH_SPACE, 1'b1, 1'b0);
    push_item(tvls_pkg::CH_EQ, 1'b1, 1'b0);
    push_item("x", 1'b1, 1'b0);
    push_item(8'hFF, 1'b0, 1'b1);
    // segment without '=' that errors on the last byte
    push_item("k", 1'b1, 1'b0);
    push_item(tvls_pkg::CH_SEMI, 1'b1, 1'b1);
    // empty message
    push_item(8'h00, 1'b0, 1'b1);
    // extreme byte codes, bare marker mid-list, blank trailing segment
    push_item(8'h00, 1'b1, 1'b0);
    push_item(tvls_pkg::CH_EQ, 1'b1, 1'b0);
    push_item(8'hFF, 1'b1, 1'b0);
    push_item(8'hA5, 1'b0, 1'b0);
    push_item(tvls_pkg::CH_SEMI, 1'b1, 1'b0);
    push_item(tvls_pkg::CH_CR, 1'b1, 1'b0);
    push_item(tvls_pkg::CH_LF, 1'b1, 1'b1);
    // empty value, list ends on '='
    push_item("x", 1'b1, 1'b0);
    push_item(tvls_pkg::CH_EQ, 1'b1, 1'b1);
    // mid-list error followed by discarded bytes
    push_item("y", 1'b1, 1'b0);
    push_item(tvls_pkg::CH_SEMI, 1'b1, 1'b0);
    push_item(tvls_pkg::CH_TAB, 1'b1, 1'b0);
    push_item("z", 1'b1, 1'b1);

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 26;
          recv_idle_pct = 87;
        end
        1: begin
          send_idle_pct = 87;
          recv_idle_pct = 26;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          hold_request = 1'b1;
        end
      endcase
      target = useful_items + PHASE_ITEMS;
      while (useful_items < target) begin
        if (byte_queue.size() < 32) queue_random_message();
        else @(posedge clk);
      end
    end

    repeat (20) queue_random_message();

    while (byte_queue.size() > 0 || in_valid) @(posedge clk);
    while (span_queue.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
